// ===== sv/lir_pkg.sv =====
// ----------------------------------------------------------------------------
// lir_pkg
// Shared types, widths and constants of the linear interpolation resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package lir_pkg;

    localparam int SAMPLE_W   = 18;  // Q2.15 input sample
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int ACC_W      = SAMPLE_W + 2;
    localparam int STEP_W     = 20;  // rate step register
    localparam int PCM_W      = 16;
    localparam int PCM_FRAC_W = 15;  // fraction bits of the input sample

    localparam int DEF_MAX_OUTPUTS    = 16;
    localparam int DEF_STEP_FRAC_BITS = 16;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [DIFF_W-1:0]   t_diff;
    typedef logic signed [ACC_W-1:0]    t_acc;
    typedef logic signed [PCM_W-1:0]    t_pcm;
    typedef logic        [STEP_W-1:0]   t_step;

    localparam t_step RATE_STEP_RESET = 20'd131072;
    localparam logic [PCM_FRAC_W-1:0] PCM_FULL = '1;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_RATE_STEP    = 1'b0,
        REG_PASS_THROUGH = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_SUM,
        ST_MAG,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load_sum;
        logic load_mag;
    } t_pcm_ctl;

endpackage

`default_nettype wire

// ===== sv/lir_sample_if.sv =====
// ----------------------------------------------------------------------------
// lir_sample_if
// Valid/ready channel carrying one input audio sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface lir_sample_if;
    import lir_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

// ===== sv/lir_result_if.sv =====
// ----------------------------------------------------------------------------
// lir_result_if
// Valid/ready channel carrying one PCM result and its end-of-run flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface lir_result_if;
    import lir_pkg::*;

    logic valid;
    logic ready;
    t_pcm pcm_out;
    logic last_of_run;

    modport source (output valid, output pcm_out, output last_of_run, input ready);
    modport sink   (input valid, input pcm_out, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== sv/linear_interp_resampler_unit.sv =====
// ----------------------------------------------------------------------------
// linear_interp_resampler_unit
// Streaming linear interpolation sample-rate converter with APB registers.
// ----------------------------------------------------------------------------
// Each accepted Q2.15 sample closes the interval from the previous sample; for
// every read position inside it the block emits prev*(1-f)+cur*f, clamped to
// +/-1 and scaled to 16-bit PCM, with last_of_run set on the final result of
// that sample. The interpolation product is formed by a bit-serial multiplier
// that takes one fraction bit per cycle; the sum, magnitude and emit steps
// follow, and a result may wait there for the output register to free up.
// One input sample is processed at a time; a finished result sits in an output
// register, so the next sample is taken while it waits. Registers: rate_step
// at 0x0 (Q4.F input/output rate ratio, reset 0x20000), pass_through at 0x4.
// Write them only while the block is idle.
`default_nettype none

module linear_interp_resampler_unit #(
    parameter int MAX_OUTPUTS_PER_SAMPLE = lir_pkg::DEF_MAX_OUTPUTS,
    parameter int STEP_FRAC_BITS         = lir_pkg::DEF_STEP_FRAC_BITS
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    lir_sample_if.sink                       i_sample,
    lir_result_if.source                     o_result,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [lir_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire [lir_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lir_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import lir_pkg::*;

    localparam int PH_W  = ((STEP_FRAC_BITS > STEP_W) ? STEP_FRAC_BITS : STEP_W) + 1;
    localparam int CNT_W = $clog2(MAX_OUTPUTS_PER_SAMPLE + 1);
    localparam logic [PH_W-1:0]  PHASE_ONE = {{(PH_W-1){1'b0}}, 1'b1} << STEP_FRAC_BITS;
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_OUTPUTS_PER_SAMPLE);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(MAX_OUTPUTS_PER_SAMPLE - 1);

    t_state           r_state;
    t_state           n_state;
    t_step            r_rate_step;
    logic             r_pass;
    t_sample          r_prev;
    logic [PH_W-1:0]  r_phase;
    logic [CNT_W-1:0] r_cnt;
    logic             r_is_pass;
    logic             r_last;
    t_sample          r_base;
    t_diff            r_diff;
    logic             r_out_valid;
    t_pcm             r_pcm;
    logic             r_out_last;

    logic                      cfg_wr;
    t_reg_idx                  cfg_idx;
    logic                      in_ready;
    logic                      in_xfer;
    logic                      run;
    logic                      mul_start;
    logic                      finish;
    logic                      slot_free;
    logic                      out_load;
    logic [PH_W-1:0]           phase_sum;
    logic                      below_one;
    logic [STEP_FRAC_BITS-1:0] mul_frac;
    logic                      mul_busy;
    t_acc                      mul_acc;
    logic [STEP_FRAC_BITS-1:0] mul_lo;
    t_pcm_ctl                  pcm_ctl;
    t_pcm                      pcm_val;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[2]);

    always_comb begin
        unique case (cfg_idx)
            REG_RATE_STEP:    prdata = {{(APB_DATA_W-STEP_W){1'b0}}, r_rate_step};
            REG_PASS_THROUGH: prdata = {{(APB_DATA_W-1){1'b0}}, r_pass};
            default:          prdata = '0;
        endcase
    end

    // ---------------- control ----------------
    assign phase_sum = r_phase + {{(PH_W-STEP_W){1'b0}}, r_rate_step};
    assign below_one = r_phase < PHASE_ONE;
    assign run       = r_is_pass || (below_one && (r_cnt < CNT_MAX));
    assign slot_free = !r_out_valid || o_result.ready;
    assign in_xfer   = i_sample.valid && in_ready;
    assign mul_frac  = r_is_pass ? '0 : r_phase[STEP_FRAC_BITS-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_xfer) n_state = ST_CHECK;
            ST_CHECK: n_state = run ? ST_MUL : ST_IDLE;
            ST_MUL:   if (!mul_busy) n_state = ST_SUM;
            ST_SUM:   n_state = ST_MAG;
            ST_MAG:   n_state = ST_EMIT;
            ST_EMIT:  if (slot_free) n_state = r_is_pass ? ST_IDLE : ST_CHECK;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready         = 1'b0;
        mul_start        = 1'b0;
        finish           = 1'b0;
        out_load         = 1'b0;
        pcm_ctl.load_sum = 1'b0;
        pcm_ctl.load_mag = 1'b0;
        unique case (r_state)
            ST_IDLE:  in_ready = i_rst_n;
            ST_CHECK: begin
                mul_start = run;
                finish    = !run;
            end
            ST_MUL:   ;
            ST_SUM:   pcm_ctl.load_sum = 1'b1;
            ST_MAG:   pcm_ctl.load_mag = 1'b1;
            ST_EMIT:  out_load = slot_free;
            default:  ;
        endcase
    end

    assign i_sample.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rate_step <= RATE_STEP_RESET;
            r_pass      <= 1'b0;
            r_prev      <= '0;
            r_phase     <= '0;
            r_cnt       <= '0;
            r_is_pass   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_RATE_STEP:    r_rate_step <= pwdata[STEP_W-1:0];
                    REG_PASS_THROUGH: r_pass      <= pwdata[0];
                    default:          ;
                endcase
            end
            if (in_xfer) begin
                r_prev    <= i_sample.sample_in;
                r_is_pass <= r_pass;
                r_cnt     <= '0;
            end
            if (mul_start && !r_is_pass) begin
                r_phase <= phase_sum;
                r_cnt   <= r_cnt + CNT_W'(1);
            end
            // close the interval: wrap the phase, or restart it after a cut-off run
            if (finish) begin
                r_phase <= below_one ? '0 : r_phase - PHASE_ONE;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_base <= r_pass ? i_sample.sample_in : r_prev;
            r_diff <= r_pass ? '0
                             : {i_sample.sample_in[SAMPLE_W-1], i_sample.sample_in}
                               - {r_prev[SAMPLE_W-1], r_prev};
        end
        if (mul_start) begin
            r_last <= r_is_pass || (phase_sum >= PHASE_ONE) || (r_cnt == CNT_LAST);
        end
        if (out_load) begin
            r_pcm      <= pcm_val;
            r_out_last <= r_last;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.pcm_out     = r_pcm;
    assign o_result.last_of_run = r_out_last;

    // ---------------- datapath ----------------
    lir_serial_mul #(
        .STEP_FRAC_BITS (STEP_FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_diff  (r_diff),
        .i_frac  (mul_frac),
        .o_busy  (mul_busy),
        .o_acc   (mul_acc),
        .o_lo    (mul_lo)
    );

    lir_pcm_conv #(
        .STEP_FRAC_BITS (STEP_FRAC_BITS)
    ) u_pcm (
        .i_clk  (i_clk),
        .i_ctl  (pcm_ctl),
        .i_acc  (mul_acc),
        .i_base (r_base),
        .i_lo   (mul_lo),
        .o_pcm  (pcm_val)
    );

    // ---------------- checks ----------------
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("result count ran past the per-sample limit");

    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ((r_phase >> STEP_W) == '0))
        else $error("read phase out of range between samples");

    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_start |-> !mul_busy)
        else $error("multiplier started while still busy");

endmodule

`default_nettype wire

// ===== sv/lir_serial_mul.sv =====
// ----------------------------------------------------------------------------
// lir_serial_mul
// Serial-parallel multiplier: signed difference times unsigned fraction, one
// fraction bit per cycle, low product bits shifted out into a register.
// ----------------------------------------------------------------------------
`default_nettype none

module lir_serial_mul #(
    parameter int STEP_FRAC_BITS = lir_pkg::DEF_STEP_FRAC_BITS
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    input  lir_pkg::t_diff           i_diff,
    input  wire [STEP_FRAC_BITS-1:0] i_frac,
    output logic                     o_busy,
    output lir_pkg::t_acc            o_acc,
    output logic [STEP_FRAC_BITS-1:0] o_lo
);
    import lir_pkg::*;

    localparam int CNT_W = $clog2(STEP_FRAC_BITS + 1);

    logic                      r_busy;
    logic [CNT_W-1:0]          r_cnt;
    t_acc                      r_acc;
    t_diff                     r_diff;
    logic [STEP_FRAC_BITS-1:0] r_frac;
    logic [STEP_FRAC_BITS-1:0] r_lo;
    t_acc                      n_sum;

    // add the multiplicand when the current fraction bit is set
    always_comb begin
        n_sum = r_acc + (r_frac[0] ? {r_diff[DIFF_W-1], r_diff} : t_acc'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(STEP_FRAC_BITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc  <= '0;
            r_diff <= i_diff;
            r_frac <= i_frac;
            r_lo   <= '0;
        end else if (r_busy) begin
            r_acc  <= n_sum >>> 1;
            r_lo   <= {n_sum[0], r_lo[STEP_FRAC_BITS-1:1]};
            r_frac <= r_frac >> 1;
        end
    end

    assign o_busy = r_busy;
    assign o_acc  = r_acc;
    assign o_lo   = r_lo;

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("multiplier busy with an exhausted bit count");

endmodule

`default_nettype wire

// ===== sv/lir_pcm_conv.sv =====
// ----------------------------------------------------------------------------
// lir_pcm_conv
// Adds the base sample to the product, takes the magnitude, then clamps and
// scales it by 32767 with truncation toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module lir_pcm_conv #(
    parameter int STEP_FRAC_BITS = lir_pkg::DEF_STEP_FRAC_BITS
) (
    input  wire                       i_clk,
    input  lir_pkg::t_pcm_ctl         i_ctl,
    input  lir_pkg::t_acc             i_acc,
    input  lir_pkg::t_sample          i_base,
    input  wire [STEP_FRAC_BITS-1:0]  i_lo,
    output lir_pkg::t_pcm             o_pcm
);
    import lir_pkg::*;

    localparam int CMP_W = STEP_FRAC_BITS + PCM_FRAC_W;

    t_acc                      r_hi;
    logic [STEP_FRAC_BITS-1:0] r_lo;
    logic                      r_neg;
    logic [ACC_W-1:0]          r_mag_hi;
    logic [STEP_FRAC_BITS-1:0] r_mag_lo;

    logic                      n_neg;
    logic [ACC_W-1:0]          n_mag_hi;
    logic [STEP_FRAC_BITS-1:0] n_mag_lo;
    logic                      clamp;
    logic [CMP_W-1:0]          lhs;
    logic [CMP_W-1:0]          rhs;
    logic                      dec;
    logic [PCM_FRAC_W-1:0]     q;
    t_pcm                      q_ext;

    function automatic logic [STEP_FRAC_BITS-1:0] neg_lo(
        input logic [STEP_FRAC_BITS-1:0] lo,
        input logic                      neg
    );
        neg_lo = neg ? -lo : lo;
    endfunction

    // value = hi * 2^F + lo, negate across the split
    always_comb begin
        n_neg    = r_hi[ACC_W-1];
        n_mag_lo = neg_lo(r_lo, n_neg);
        if (!n_neg) begin
            n_mag_hi = r_hi;
        end else if (r_lo == '0) begin
            n_mag_hi = -r_hi;
        end else begin
            n_mag_hi = ~r_hi;
        end
    end

    // mag*32767 >> (15+F) is the integer part, less one when the
    // fraction part times 32767 falls below the integer part
    always_comb begin
        clamp = |r_mag_hi[ACC_W-1:PCM_FRAC_W];
        lhs   = {r_mag_lo, {PCM_FRAC_W{1'b0}}} - {{PCM_FRAC_W{1'b0}}, r_mag_lo};
        rhs   = {r_mag_hi[PCM_FRAC_W-1:0], {STEP_FRAC_BITS{1'b0}}};
        dec   = lhs < rhs;
        q     = clamp ? PCM_FULL : r_mag_hi[PCM_FRAC_W-1:0] - PCM_FRAC_W'(dec);
        q_ext = {1'b0, q};
        o_pcm = r_neg ? -q_ext : q_ext;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_sum) begin
            r_hi <= i_acc + {{(ACC_W-SAMPLE_W){i_base[SAMPLE_W-1]}}, i_base};
            r_lo <= i_lo;
        end
        if (i_ctl.load_mag) begin
            r_neg    <= n_neg;
            r_mag_hi <= n_mag_hi;
            r_mag_lo <= n_mag_lo;
        end
    end

endmodule

`default_nettype wire

// ===== tb/lir_resampler_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_resampler_checker
// Watches the sample, result and register ports of the resampler, predicts
// the interpolated PCM stream and compares every result transfer in order.
// ----------------------------------------------------------------------------
`default_nettype none

module lir_resampler_checker #(
    parameter int MAX_OUTPUTS_PER_SAMPLE = lir_pkg::DEF_MAX_OUTPUTS,
    parameter int STEP_FRAC_BITS         = lir_pkg::DEF_STEP_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    lir_sample_if                          i_sample,
    lir_result_if                          i_result,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic                           i_pready,
    input  logic [lir_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [lir_pkg::APB_DATA_W-1:0] i_pwdata,
    output int                             o_errors,
    output int                             o_pending
);
    import lir_pkg::*;

    localparam longint PHASE_ONE = 64'sd1 << STEP_FRAC_BITS;

    typedef struct packed {
        t_pcm pcm;
        logic last;
    } t_pcm_result;

    t_pcm_result pcm_expect_q[$];
    t_sample     prev_sample;
    longint      read_pos;
    t_step       step_reg;
    logic        bypass;
    int          err_cnt = 0;

    assign o_errors = err_cnt;

    // clamp to +/-1.0, scale by 32767, truncate toward zero
    function automatic t_pcm scale_to_pcm(input longint v, input int fbits);
        longint full;
        longint mag;
        longint q;
        full = 64'sd1 << fbits;
        mag  = (v < 0) ? -v : v;
        if (mag > full)
            mag = full;
        q = (mag * 32767) >>> fbits;
        if (v < 0)
            q = -q;
        return t_pcm'(q);
    endfunction

    function automatic void interpolate_sample(input t_sample cur);
        longint      prev;
        longint      acc;
        int          n;
        t_pcm_result res;
        prev        = longint'(prev_sample);
        prev_sample = cur;
        if (bypass) begin
            res.pcm  = scale_to_pcm(longint'(cur), PCM_FRAC_W);
            res.last = 1'b1;
            pcm_expect_q.insert(pcm_expect_q.size(), res);
            return;
        end
        n = 0;
        while (read_pos < PHASE_ONE && n < MAX_OUTPUTS_PER_SAMPLE) begin
            acc      = prev * (PHASE_ONE - read_pos) + longint'(cur) * read_pos;
            res.pcm  = scale_to_pcm(acc, PCM_FRAC_W + STEP_FRAC_BITS);
            res.last = 1'b0;
            pcm_expect_q.insert(pcm_expect_q.size(), res);
            n++;
            read_pos += longint'(step_reg);
        end
        // positions left over after the output cap are dropped
        if (read_pos < PHASE_ONE)
            read_pos = 0;
        else
            read_pos -= PHASE_ONE;
        if (n > 0) begin
            res      = pcm_expect_q.pop_back();
            res.last = 1'b1;
            pcm_expect_q.insert(pcm_expect_q.size(), res);
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_pcm_result got;
        t_pcm_result want;
        if (!i_rst_n) begin
            prev_sample = '0;
            read_pos    = 0;
            step_reg    = RATE_STEP_RESET;
            bypass      = 1'b0;
            pcm_expect_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[2]))
                    REG_RATE_STEP:    step_reg = i_pwdata[STEP_W-1:0];
                    REG_PASS_THROUGH: bypass   = i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_sample.valid && i_sample.ready)
                interpolate_sample(i_sample.sample_in);
            if (i_result.valid && i_result.ready) begin
                got.pcm  = i_result.pcm_out;
                got.last = i_result.last_of_run;
                if (pcm_expect_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result transfer: expected none, actual %0d last %0b",
                             $time, got.pcm, got.last);
                end else begin
                    want = pcm_expect_q.pop_front();
                    if (got.pcm !== want.pcm) begin
                        err_cnt++;
                        $display("%0t: pcm_out mismatch: expected %0d, actual %0d",
                                 $time, want.pcm, got.pcm);
                    end
                    if (got.last !== want.last) begin
                        err_cnt++;
                        $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                                 $time, want.last, got.last);
                    end
                end
            end
        end
        o_pending = pcm_expect_q.size();
    end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the linear interpolation resampler.
// ----------------------------------------------------------------------------
// Directed corner samples over the step extremes and pass-through, then random
// phases with random register settings, random gaps on both channels, one
// stretch without gaps and one long output hold-off that backs up the input.
`default_nettype none

module tb;
    import lir_pkg::*;

    localparam int     CLK_HALF      = 4;
    localparam int     RESET_CYCLES  = 3;
    localparam int     SETTLE_CYCLES = 48;   // covers a pass-through sample in flight
    localparam int     HOLD_CYCLES   = 400;
    localparam int     RAND_PHASES   = 8;
    localparam int     PHASE_ITEMS   = 17;
    localparam longint CYCLE_LIMIT   = 400000;

    localparam t_step STEP_UNITY     = 20'd65536;
    localparam t_step STEP_SIXTEENTH = 20'd4096;
    localparam t_step STEP_EIGHT     = 20'd524288;
    localparam t_step STEP_TINY      = 20'd1000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int     errors;
    int     pending;
    int     idle_pct;
    logic   hold_req;
    longint cycles = 0;

    lir_sample_if smp_if ();
    lir_result_if res_if ();

    linear_interp_resampler_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp_if),
        .o_result (res_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    lir_resampler_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sample  (smp_if),
        .i_result  (res_if),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_pready  (pready),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: random back-pressure plus one long hold-off on request
    initial begin : result_sink
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                res_if.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // valid stays high from one transfer to the next unless a gap is taken
    task automatic send_sample(input t_sample s);
        if ($urandom_range(99) < idle_pct) begin
            smp_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        smp_if.valid     <= 1'b1;
        smp_if.sample_in <= s;
        do @(posedge i_clk); while (!smp_if.ready);
    endtask

    task automatic wait_idle();
        smp_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // a sample with no results may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_rate(input t_step step, input logic bypass);
        t_reg_idx idx;
        wait_idle();
        for (int r = 0; r < 2; r++) begin
            idx = t_reg_idx'(r[0]);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= (idx == REG_RATE_STEP) ? APB_DATA_W'(step) : APB_DATA_W'(bypass);
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin : stimulus
        t_sample     corners [8];
        t_sample     s;
        t_step       step;
        logic        bypass;
        int unsigned sel;

        corners = '{18'sh00000, 18'sh1FFFF, 18'sh20000, 18'sh3FFFF,
                    18'sh08000, 18'sh38000, 18'sh07FFF, 18'sh00001};

        i_rst_n          <= 1'b0;
        smp_if.valid     <= 1'b0;
        smp_if.sample_in <= '0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        idle_pct         <= 25;
        hold_req         <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting: step 2.0, every other sample gives no result
        foreach (corners[i]) send_sample(corners[i]);

        // exactly sixteen positions per sample
        program_rate(STEP_SIXTEENTH, 1'b0);
        send_sample(corners[1]);
        send_sample(corners[2]);

        // zero and tiny steps hit the output cap
        program_rate('0, 1'b0);
        send_sample(corners[1]);
        send_sample(corners[5]);
        program_rate(STEP_TINY, 1'b0);
        send_sample(corners[6]);

        program_rate(STEP_EIGHT, 1'b0);
        send_sample(corners[1]);
        send_sample(corners[2]);
        send_sample(corners[7]);

        program_rate(STEP_EIGHT, 1'b1);
        for (int i = 1; i <= 4; i++) send_sample(corners[i]);

        program_rate(STEP_UNITY, 1'b0);
        for (int i = 0; i < 3; i++) send_sample(corners[i]);

        for (int p = 0; p < RAND_PHASES; p++) begin
            sel = $urandom_range(19);
            if (sel < 14)
                step = t_step'($urandom_range(4096, 131072));
            else if (sel < 17)
                step = t_step'($urandom_range(131073, 524288));
            else if (sel < 19)
                step = t_step'($urandom_range(0, 4095));
            else
                step = t_step'($urandom());
            bypass = ($urandom_range(3) == 0);
            program_rate(step, bypass);
            idle_pct <= (p == 2) ? 0 : 25;
            if (p == 4)
                hold_req <= 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                case ($urandom_range(3))
                    0, 1:    s = t_sample'($urandom());
                    2:       s = t_sample'(int'($urandom_range(0, 65536)) - 32768);
                    default: s = t_sample'(int'($urandom_range(0, 128)) - 64);
                endcase
                send_sample(s);
            end
        end

        wait_idle();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

// ===== linear_interp_resampler_unit.f =====
sv/lir_pkg.sv
sv/lir_sample_if.sv
sv/lir_result_if.sv
sv/lir_serial_mul.sv
sv/lir_pcm_conv.sv
sv/linear_interp_resampler_unit.sv
tb/lir_resampler_checker.sv
tb/tb.sv
